[design/assert_macros.svh]
// Assertion macros used by the checker file of the CSV field parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define CSVP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define CSVP_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[design/csvp_pkg.sv]
// Package with the types, codes and constants of the CSV field parser.
package csvp_pkg;

  localparam int unsigned CfgIdxW = 8;

  localparam logic [CfgIdxW-1:0] CFG_COL_SEP = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROW_SEP = 8'd1;

  localparam logic [7:0] COL_SEP_RST = 8'd44;
  localparam logic [7:0] ROW_SEP_RST = 8'd10;

  localparam logic [7:0] QUOTE_BYTE = 8'h22;
  localparam logic [7:0] CR_BYTE    = 8'h0D;
  localparam logic [8:0] NONE_MARK  = 9'h100;

  localparam logic [1:0] TERM_COL     = 2'd0;
  localparam logic [1:0] TERM_ROW     = 2'd1;
  localparam logic [1:0] TERM_END     = 2'd2;
  localparam logic [1:0] TERM_NOFIELD = 2'd3;

  localparam logic [1:0] WARN_NONE    = 2'd0;
  localparam logic [1:0] WARN_UNESC   = 2'd1;
  localparam logic [1:0] WARN_UNTERM  = 2'd2;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [31:0] LINE_RST = 32'd1;
  localparam logic [31:0] LINE_MAX = 32'hFFFF_FFFF;

  localparam int unsigned MaxRes = 3;

  typedef enum logic [1:0] {
    PH_START    = 2'd0,
    PH_UNQUOTED = 2'd1,
    PH_QUOTED   = 2'd2
  } phase_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } csvp_in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        kind;
    logic [1:0]  terminator;
    logic [1:0]  warning;
    logic [31:0] line_number;
    logic        last;
  } csvp_out_t;

  typedef struct packed {
    phase_e      phase;
    logic [8:0]  prev;
    logic [8:0]  prev2;
    logic [1:0]  held;
    logic [31:0] line;
  } csvp_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       kind;
    logic [1:0] term;
  } csvp_ent_t;

  typedef struct packed {
    logic [1:0]               cnt;
    csvp_ent_t [MaxRes-1:0]   ent;
    logic [1:0]               warning;
    logic [31:0]              line;
  } csvp_bundle_t;

endpackage

[design/csvp_step.sv]
// Next-state and result logic for one registered input item.
module csvp_step (
  input  csvp_pkg::csvp_state_t  st_i,
  input  csvp_pkg::csvp_in_t     item_i,
  input  logic [7:0]             col_sep_i,
  input  logic [7:0]             row_sep_i,
  output csvp_pkg::csvp_state_t  st_o,
  output csvp_pkg::csvp_bundle_t bnd_o
);

  logic [7:0]  c;
  logic        eof;
  logic        is_col;
  logic        is_row;
  logic        is_quote;
  logic        is_cr;
  logic        pq;
  logic        ends;
  logic [8:0]  eff_prev;
  logic [8:0]  eff_prev2;
  logic [1:0]  eff_held;
  logic        unq_go;
  logic        do_rel;
  logic        tail_en;
  logic        tail_end;
  logic [1:0]  tail_term;
  logic        bump;
  logic [1:0]  warn;
  logic [1:0]  rel_cnt;
  csvp_pkg::csvp_ent_t   tail;
  csvp_pkg::csvp_state_t nxt;

  assign c        = item_i.in_byte;
  assign eof      = item_i.end_of_input;
  assign is_col   = (c == col_sep_i);
  assign is_row   = (c == row_sep_i);
  assign is_quote = (c == csvp_pkg::QUOTE_BYTE);
  assign is_cr    = (c == csvp_pkg::CR_BYTE);
  assign pq       = (st_i.prev == {1'b0, csvp_pkg::QUOTE_BYTE});
  assign ends     = (!eof && is_col && pq) || (!eof && is_row && pq)
                 || (!eof && is_row && st_i.prev == {1'b0, csvp_pkg::CR_BYTE}
                     && st_i.prev2 == {1'b0, csvp_pkg::QUOTE_BYTE})
                 || (eof && pq);

  always_comb begin
    eff_prev  = st_i.prev;
    eff_prev2 = st_i.prev2;
    eff_held  = st_i.held;
    if (st_i.phase != csvp_pkg::PH_QUOTED && st_i.phase != csvp_pkg::PH_UNQUOTED) begin
      eff_prev  = csvp_pkg::NONE_MARK;
      eff_prev2 = csvp_pkg::NONE_MARK;
      eff_held  = 2'd0;
    end
    nxt       = st_i;
    nxt.prev  = eff_prev;
    nxt.prev2 = eff_prev2;
    nxt.held  = eff_held;
    unq_go    = 1'b0;
    do_rel    = 1'b0;
    tail_en   = 1'b0;
    tail_end  = 1'b0;
    tail_term = csvp_pkg::TERM_COL;
    bump      = 1'b0;
    warn      = csvp_pkg::WARN_NONE;

    if (st_i.phase == csvp_pkg::PH_QUOTED) begin
      if (!eof && is_row) begin
        bump = 1'b1;
      end
      if (!eof && is_quote && pq) begin
        do_rel   = 1'b1;
        nxt.prev = csvp_pkg::NONE_MARK;
        nxt.held = 2'd0;
      end else if (ends) begin
        tail_en   = 1'b1;
        tail_end  = 1'b1;
        tail_term = eof ? csvp_pkg::TERM_END :
                    (is_col ? csvp_pkg::TERM_COL : csvp_pkg::TERM_ROW);
        nxt.phase = csvp_pkg::PH_START;
        nxt.prev  = csvp_pkg::NONE_MARK;
        nxt.prev2 = csvp_pkg::NONE_MARK;
        nxt.held  = 2'd0;
      end else if (eof) begin
        do_rel    = 1'b1;
        warn      = csvp_pkg::WARN_UNTERM;
        tail_en   = 1'b1;
        tail_end  = 1'b1;
        tail_term = csvp_pkg::TERM_END;
        nxt.phase = csvp_pkg::PH_START;
        nxt.prev  = csvp_pkg::NONE_MARK;
        nxt.prev2 = csvp_pkg::NONE_MARK;
        nxt.held  = 2'd0;
      end else begin
        if (pq && !is_cr) begin
          warn = csvp_pkg::WARN_UNESC;
        end
        nxt.prev2 = st_i.prev;
        nxt.prev  = {1'b0, c};
        if (pq && is_cr) begin
          nxt.held = 2'd2;
        end else begin
          do_rel = 1'b1;
          if (is_quote) begin
            nxt.held = 2'd1;
          end else begin
            tail_en  = 1'b1;
            nxt.held = 2'd0;
          end
        end
      end
    end else if (st_i.phase == csvp_pkg::PH_UNQUOTED) begin
      unq_go = 1'b1;
    end else begin
      if (eof) begin
        tail_en   = 1'b1;
        tail_end  = 1'b1;
        tail_term = csvp_pkg::TERM_NOFIELD;
        nxt.phase = csvp_pkg::PH_START;
      end else if (is_quote) begin
        nxt.phase = csvp_pkg::PH_QUOTED;
      end else begin
        nxt.phase = csvp_pkg::PH_UNQUOTED;
        unq_go    = 1'b1;
      end
    end

    if (unq_go) begin
      if (eof || is_col || is_row) begin
        if (!eof && is_row) begin
          bump = 1'b1;
        end else begin
          do_rel = 1'b1;
        end
        tail_en   = 1'b1;
        tail_end  = 1'b1;
        tail_term = eof ? csvp_pkg::TERM_END :
                    (is_col ? csvp_pkg::TERM_COL : csvp_pkg::TERM_ROW);
        nxt.phase = csvp_pkg::PH_START;
        nxt.prev  = csvp_pkg::NONE_MARK;
        nxt.prev2 = csvp_pkg::NONE_MARK;
        nxt.held  = 2'd0;
      end else begin
        do_rel    = 1'b1;
        nxt.prev2 = eff_prev;
        nxt.prev  = {1'b0, c};
        if (is_cr) begin
          nxt.held = 2'd1;
        end else begin
          tail_en  = 1'b1;
          nxt.held = 2'd0;
        end
      end
    end

    if (bump && st_i.line != csvp_pkg::LINE_MAX) begin
      nxt.line = st_i.line + 32'd1;
    end
  end

  assign rel_cnt = do_rel ? eff_held : 2'd0;

  assign tail.data = tail_end ? 8'd0 : c;
  assign tail.kind = tail_end ? csvp_pkg::KIND_END : csvp_pkg::KIND_BYTE;
  assign tail.term = tail_end ? tail_term : csvp_pkg::TERM_COL;

  always_comb begin
    bnd_o.cnt     = rel_cnt + {1'b0, tail_en};
    bnd_o.warning = warn;
    bnd_o.line    = nxt.line;
    bnd_o.ent[2]  = tail;
    case (rel_cnt)
      2'd2: begin
        bnd_o.ent[0] = '{data: eff_prev2[7:0], kind: csvp_pkg::KIND_BYTE,
                         term: csvp_pkg::TERM_COL};
        bnd_o.ent[1] = '{data: eff_prev[7:0], kind: csvp_pkg::KIND_BYTE,
                         term: csvp_pkg::TERM_COL};
      end
      2'd1: begin
        bnd_o.ent[0] = '{data: eff_prev[7:0], kind: csvp_pkg::KIND_BYTE,
                         term: csvp_pkg::TERM_COL};
        bnd_o.ent[1] = tail;
      end
      default: begin
        bnd_o.ent[0] = tail;
        bnd_o.ent[1] = tail;
      end
    endcase
  end

  assign st_o = nxt;

endmodule

[design/csvp_emit.sv]
// Result register that holds the results of one item and hands them out one by one.
module csvp_emit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  csvp_pkg::csvp_bundle_t bnd_i,
  output logic                   free_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output csvp_pkg::csvp_out_t    out_data_o
);

  logic                   vld_q;
  logic [1:0]             idx_q;
  csvp_pkg::csvp_bundle_t bnd_q;
  csvp_pkg::csvp_ent_t    cur;
  logic                   is_last;

  always_comb begin
    case (idx_q)
      2'd0:    cur = bnd_q.ent[0];
      2'd1:    cur = bnd_q.ent[1];
      default: cur = bnd_q.ent[2];
    endcase
  end

  assign is_last = (idx_q == bnd_q.cnt - 2'd1);
  assign free_o  = !vld_q || (out_ready_i && is_last);

  assign out_valid_o             = vld_q;
  assign out_data_o.out_byte     = cur.data;
  assign out_data_o.kind         = cur.kind;
  assign out_data_o.terminator   = cur.term;
  assign out_data_o.warning      = bnd_q.warning;
  assign out_data_o.line_number  = bnd_q.line;
  assign out_data_o.last         = is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= 2'd0;
    end else if (load_i) begin
      vld_q <= 1'b1;
      idx_q <= 2'd0;
    end else if (vld_q && out_ready_i) begin
      if (is_last) begin
        vld_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bnd_q <= bnd_i;
    end
  end

endmodule

[design/csv_field_parser.sv]
// Top level of the CSV field parser: input register, parser state and configuration.
//
//   channel | direction | handshake                  | payload
//   in      | input     | in_valid_i / in_ready_o    | in_data_i (csvp_in_t)
//   out     | output    | out_valid_o / out_ready_i  | out_data_o (csvp_out_t)
//   cfg     | input     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// An item waits in the input register, where the parser state and its results are worked
// out combinationally, until the item can go on (at once if it has no results, else once
// the result register is free); its results then leave the result register at one per cycle
// while out_ready_i is high, so the rate is one item per cycle for items with at most one result.
// Reset clears the parser state, the line count and the separators to their defaults.
// A stalled output fills the result register and then the input register, then in_ready_o drops.
module csv_field_parser (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  csvp_pkg::csvp_in_t                    in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output csvp_pkg::csvp_out_t                   out_data_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [csvp_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [7:0]                            cfg_data_i
);

  logic                   in_vld_q;
  csvp_pkg::csvp_in_t     in_q;
  csvp_pkg::csvp_state_t  st_q;
  csvp_pkg::csvp_state_t  st_d;
  csvp_pkg::csvp_bundle_t bnd;
  logic [7:0]             col_sep_q;
  logic [7:0]             row_sep_q;
  logic                   emit_free;
  logic                   fire;
  logic                   load;

  assign fire        = in_vld_q && (bnd.cnt == 2'd0 || emit_free);
  assign load        = fire && (bnd.cnt != 2'd0);
  assign in_ready_o  = !in_vld_q || fire;
  assign cfg_ready_o = 1'b1;

  csvp_step u_step (
    .st_i      (st_q),
    .item_i    (in_q),
    .col_sep_i (col_sep_q),
    .row_sep_i (row_sep_q),
    .st_o      (st_d),
    .bnd_o     (bnd)
  );

  csvp_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .bnd_i       (bnd),
    .free_o      (emit_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      st_q     <= '{phase: csvp_pkg::PH_START, prev: csvp_pkg::NONE_MARK,
                    prev2: csvp_pkg::NONE_MARK, held: 2'd0, line: csvp_pkg::LINE_RST};
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (fire) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_sep_q <= csvp_pkg::COL_SEP_RST;
      row_sep_q <= csvp_pkg::ROW_SEP_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == csvp_pkg::CFG_COL_SEP) begin
        col_sep_q <= cfg_data_i;
      end else if (cfg_index_i == csvp_pkg::CFG_ROW_SEP) begin
        row_sep_q <= cfg_data_i;
      end
    end
  end

endmodule

[design/csvp_chk.sv]
// Port-level checker for the CSV field parser and its bind to the top level.
`include "assert_macros.svh"

module csvp_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input csvp_pkg::csvp_out_t out_data_o
);

  logic out_wait;
  logic out_end;
  logic out_unterm;
  logic out_eoi_end;

  assign out_wait    = out_valid_o && !out_ready_i;
  assign out_end     = out_valid_o && (out_data_o.kind == csvp_pkg::KIND_END);
  assign out_unterm  = out_valid_o && out_data_o.last
                    && (out_data_o.warning == csvp_pkg::WARN_UNTERM);
  assign out_eoi_end = (out_data_o.kind == csvp_pkg::KIND_END)
                    && (out_data_o.terminator == csvp_pkg::TERM_END);

  `CSVP_ASSERT(a_out_valid_holds, out_wait |=> out_valid_o, "out valid dropped")
  `CSVP_ASSERT(a_out_data_holds, out_wait |=> $stable(out_data_o), "out item changed")
  `CSVP_ASSERT(a_end_is_last, out_end |-> out_data_o.last, "field end not last")
  `CSVP_ASSERT(a_unterm_ends, out_unterm |-> out_eoi_end, "bad unterminated end")
  `CSVP_ASSERT_NR(a_reset_quiet, !rst_ni |=> !out_valid_o, "output valid in reset")

endmodule

bind csv_field_parser csvp_chk u_csvp_chk (.*);
